@@ hdl/hfp_pkg.sv @@
// hfp_pkg: types and constants shared by the host frame parser
// holds the phase and kind codes, the item structs and the default payload limit
// no dependencies
package hfp_pkg;

  // largest payload the parser accepts by default
  localparam int MAX_PAYLOAD_DEF = 512;

  // parser phase
  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_HEADER   = 3'd1,
    PH_BODY     = 3'd2,
    PH_DONE     = 3'd3,
    PH_ABORTED  = 3'd4
  } phase_t;

  // frame kind as reported on frame_kind
  typedef enum logic [2:0] {
    KIND_UNKNOWN  = 3'd0,
    KIND_NORMAL   = 3'd1,
    KIND_EXTENDED = 3'd2,
    KIND_ACK      = 3'd3,
    KIND_NACK     = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_t;

  // special header byte values
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] LEN_ERROR = 8'h01;

  // header positions that trigger a decision
  localparam logic [2:0] POS_SHORT = 3'd2;
  localparam logic [2:0] POS_EXT   = 3'd5;

  // one received item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_frame;
  } hfp_in_t;

  // one result item
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [8:0] payload_index;
    logic [2:0] frame_kind;
    logic [9:0] payload_length;
    logic       frame_done;
    logic       frame_error;
  } hfp_out_t;

endpackage

@@ hdl/hfp_in_if.sv @@
// hfp_in_if: valid/ready channel carrying received items
// depends on hfp_pkg for the item struct
interface hfp_in_if
  import hfp_pkg::*;
();
  logic    valid;
  logic    ready;
  hfp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/hfp_out_if.sv @@
// hfp_out_if: valid/ready channel carrying result items
// depends on hfp_pkg for the item struct
interface hfp_out_if
  import hfp_pkg::*;
();
  logic     valid;
  logic     ready;
  hfp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/host_frame_parser_unit.sv @@
// host_frame_parser_unit: byte-serial parser for host-link frames
// depends on hfp_pkg, hfp_in_if and hfp_out_if
//
// Takes one received byte per item and returns exactly one result item for
// it. The byte is optionally bit-reversed (reverse_bit_order, reset 1), the
// 00 FF start code is searched for, and the frame is classified as ACK, NACK,
// extended, error or normal; length checksums are checked, payload bytes are
// passed out with their index, and the data checksum is verified. After done
// or error further bytes are ignored until an item with start_frame set. An
// extended length above MAX_PAYLOAD is reported as an error. The parser
// state and the result register update at the edge the item is accepted, so
// a new item is taken every cycle while the result register is empty or
// being drained; a result waiting on a stalled sink holds off the next item.
module host_frame_parser_unit
  import hfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  hfp_in_if.sink    rx,
  hfp_out_if.source parsed
);

  // length counters wide enough for a normal length byte and the limit
  localparam int LEN_W = (MAX_PAYLOAD >= 256) ? $clog2(MAX_PAYLOAD + 1) : 8;
  localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

  // configuration
  logic reverse_bit_order;

  // parser state
  phase_t             phase, phase_next;
  logic               zero_seen, zero_seen_next;
  logic [15:0]        hdr, hdr_next;
  logic [2:0]         hdr_pos, hdr_pos_next;
  kind_t              kind_held, kind_held_next;
  logic [LEN_W-1:0]   length_held, length_held_next;
  logic [LEN_W-1:0]   bytes_passed, bytes_passed_next;
  logic [7:0]         data_sum, data_sum_next;

  // view of state after an optional start_frame clear
  phase_t             cur_phase;
  logic               cur_zero;
  logic [15:0]        cur_hdr;
  logic [2:0]         cur_pos;
  kind_t              cur_kind;
  logic [LEN_W-1:0]   cur_len;
  logic [LEN_W-1:0]   cur_passed;
  logic [7:0]         cur_sum;

  logic [7:0]         b;
  logic [2:0]         pos_inc;
  logic [7:0]         b0;
  logic [15:0]        ext_len;
  logic [7:0]         ext_sum;
  logic [7:0]         short_sum;
  logic [15:0]        len_wide;

  hfp_out_t           res;
  hfp_out_t           out_data;
  logic               out_valid;
  logic               accept;

  // handshake: take an item whenever the result register is free or draining
  assign rx.ready    = !out_valid || parsed.ready;
  assign accept      = rx.valid && rx.ready;
  assign parsed.valid = out_valid;
  assign parsed.data  = out_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_bit_order <= 1'b1;
    end else if (cfg_we) begin
      reverse_bit_order <= cfg_wdata;
    end
  end

  // optional bit reversal of the incoming byte
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = reverse_bit_order ? rx.data.rx_byte[7 - i] : rx.data.rx_byte[i];
    end
  end

  // start_frame clears the parser before the byte is handled
  always_comb begin
    if (rx.data.start_frame) begin
      cur_phase  = PH_PREAMBLE;
      cur_zero   = 1'b0;
      cur_hdr    = '0;
      cur_pos    = '0;
      cur_kind   = KIND_UNKNOWN;
      cur_len    = '0;
      cur_passed = '0;
      cur_sum    = '0;
    end else begin
      cur_phase  = phase;
      cur_zero   = zero_seen;
      cur_hdr    = hdr;
      cur_pos    = hdr_pos;
      cur_kind   = kind_held;
      cur_len    = length_held;
      cur_passed = bytes_passed;
      cur_sum    = data_sum;
    end
  end

  // header field views
  assign pos_inc   = cur_pos + 3'd1;
  assign b0        = cur_hdr[7:0];
  assign short_sum = b0 + b;
  assign ext_len   = cur_hdr;
  assign ext_sum   = cur_hdr[15:8] + cur_hdr[7:0] + b;

  // next state and result
  always_comb begin
    phase_next        = cur_phase;
    zero_seen_next    = cur_zero;
    hdr_next          = cur_hdr;
    hdr_pos_next      = cur_pos;
    kind_held_next    = cur_kind;
    length_held_next  = cur_len;
    bytes_passed_next = cur_passed;
    data_sum_next     = cur_sum;
    res               = '0;

    case (cur_phase)
      PH_PREAMBLE: begin
        if (b == BYTE_ONES && cur_zero) begin
          phase_next   = PH_HEADER;
          hdr_next     = '0;
          hdr_pos_next = '0;
        end
        zero_seen_next = (b == BYTE_ZERO);
      end
      PH_HEADER: begin
        hdr_next     = {cur_hdr[7:0], b};
        hdr_pos_next = pos_inc;
        if (pos_inc == POS_SHORT) begin
          if (b0 == BYTE_ZERO && b == BYTE_ONES) begin
            kind_held_next   = KIND_ACK;
            length_held_next = '0;
            phase_next       = PH_DONE;
            res.frame_done   = 1'b1;
          end else if (b0 == BYTE_ONES && b == BYTE_ZERO) begin
            kind_held_next   = KIND_NACK;
            length_held_next = '0;
            phase_next       = PH_DONE;
            res.frame_done   = 1'b1;
          end else if (b0 == BYTE_ONES && b == BYTE_ONES) begin
            kind_held_next = KIND_EXTENDED;
          end else if (short_sum != 8'd0) begin
            kind_held_next   = KIND_UNKNOWN;
            length_held_next = '0;
            phase_next       = PH_ABORTED;
            res.frame_error  = 1'b1;
          end else begin
            kind_held_next    = (b0 == LEN_ERROR) ? KIND_ERROR : KIND_NORMAL;
            length_held_next  = LEN_W'(b0);
            bytes_passed_next = '0;
            data_sum_next     = '0;
            phase_next        = PH_BODY;
          end
        end else if (pos_inc >= POS_EXT) begin
          if (ext_sum != 8'd0 || {1'b0, ext_len} > MAX_LEN) begin
            kind_held_next   = KIND_UNKNOWN;
            length_held_next = '0;
            phase_next       = PH_ABORTED;
            res.frame_error  = 1'b1;
          end else begin
            length_held_next  = LEN_W'(ext_len);
            bytes_passed_next = '0;
            data_sum_next     = '0;
            phase_next        = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        data_sum_next = cur_sum + b;
        if (cur_passed < cur_len) begin
          res.payload_valid = 1'b1;
          res.payload_byte  = b;
          res.payload_index = 9'(cur_passed);
          bytes_passed_next = cur_passed + 1'b1;
        end else if (data_sum_next == 8'd0) begin
          phase_next     = PH_DONE;
          res.frame_done = 1'b1;
        end else begin
          phase_next      = PH_ABORTED;
          res.frame_error = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.frame_kind     = kind_held_next;
    len_wide           = 16'(length_held_next);
    res.payload_length = len_wide[9:0];
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PREAMBLE;
      zero_seen    <= 1'b0;
      hdr          <= '0;
      hdr_pos      <= '0;
      kind_held    <= KIND_UNKNOWN;
      length_held  <= '0;
      bytes_passed <= '0;
      data_sum     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      zero_seen    <= zero_seen_next;
      hdr          <= hdr_next;
      hdr_pos      <= hdr_pos_next;
      kind_held    <= kind_held_next;
      length_held  <= length_held_next;
      bytes_passed <= bytes_passed_next;
      data_sum     <= data_sum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (parsed.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  // a result never reports done and error together
  a_done_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.frame_done && out_data.frame_error))
    else $error("frame_done and frame_error both set");

  // payload bytes only come from frames that carry a length
  a_payload_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.payload_valid) |->
      (out_data.frame_kind == KIND_NORMAL || out_data.frame_kind == KIND_EXTENDED ||
       out_data.frame_kind == KIND_ERROR))
    else $error("payload byte outside a data frame");

  // the body counter never runs past the announced length
  a_passed_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_passed <= length_held))
    else $error("payload counter beyond length");

  // a finished frame keeps its state until the next accepted item
  a_end_holds: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_DONE || phase == PH_ABORTED) && !accept) |=>
      (phase == $past(phase)))
    else $error("end phase changed without an item");

endmodule
